// ===== src/blmc_pkg.sv =====
`default_nettype none

package blmc_pkg;

    // Widths of the configuration port and of the time base.
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int TIME_W      = 32;
    localparam int LED_W       = 4;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_SCAN_PERIOD    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_INTERVAL  = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FLASH_INTERVAL = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_TIME      = 8'd3;

    // Reset values of the configuration registers.
    localparam logic [7:0]  SCAN_PERIOD_RST    = 8'd15;
    localparam logic [15:0] STEP_INTERVAL_RST  = 16'd200;
    localparam logic [15:0] FLASH_INTERVAL_RST = 16'd140;
    localparam logic [15:0] HOLD_TIME_RST      = 16'd2000;

    // LED patterns, active low.
    localparam logic [LED_W-1:0] LED_ALL_OFF = 4'hF;
    localparam logic [LED_W-1:0] LED_ALL_ON  = 4'h0;

    typedef enum logic [1:0] {
        MODE_UP    = 2'd0,
        MODE_DOWN  = 2'd1,
        MODE_FLASH = 2'd2,
        MODE_IDLE  = 2'd3
    } mode_t;

    // Scan event handed from the scheduler and debouncers to the mode logic.
    typedef struct packed {
        logic              scan;
        logic              edge_up;
        logic              edge_down;
        logic              edge_flash;
        logic              raw_flash;
        logic [TIME_W-1:0] now;
    } scan_evt_t;

endpackage

`default_nettype wire

// ===== src/blmc_debounce.sv =====
`default_nettype none

module blmc_debounce (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic scan,
    input  wire logic pressed,
    output logic      rise
);

    logic [2:0] hist_reg;
    logic [2:0] hist_next;
    logic       level_reg;
    logic       level_next;

    // Shift in the new sample; hysteresis keeps the level until all samples agree.
    always_comb
    begin
        hist_next  = {hist_reg[1:0], pressed};
        level_next = (level_reg & (|hist_next)) | (&hist_next);
        rise       = scan & level_next & ~level_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg  <= 3'b000;
            level_reg <= 1'b0;
        end
        else if (scan)
        begin
            hist_reg  <= hist_next;
            level_reg <= level_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/blmc_mode_ctrl.sv =====
`default_nettype none

module blmc_mode_ctrl (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire blmc_pkg::scan_evt_t               evt,
    input  wire logic [15:0]                       step_interval,
    input  wire logic [15:0]                       flash_interval,
    input  wire logic [15:0]                       hold_time,
    output logic [blmc_pkg::LED_W-1:0]             led_next,
    output blmc_pkg::mode_t                        mode_next
);

    import blmc_pkg::*;

    mode_t             mode_reg;
    logic [LED_W-1:0]  led_reg;
    logic [1:0]        chase_reg;
    logic [1:0]        chase_next;
    logic              hold_pending_reg;
    logic              hold_pending_next;
    logic [TIME_W-1:0] last_update_reg;
    logic [TIME_W-1:0] last_update_next;
    logic [TIME_W-1:0] press_start_reg;
    logic [TIME_W-1:0] press_start_next;

    mode_t             mode_edge;
    logic [LED_W-1:0]  led_base;
    logic [TIME_W-1:0] held;
    logic [TIME_W-1:0] elapsed;
    logic              hold_hit;
    logic              step_hit;
    logic              flash_hit;
    logic [LED_W-1:0]  chase_pattern;

    // Elapsed-time compares run in parallel with the edge logic.
    always_comb
    begin
        held          = evt.now - press_start_reg;
        elapsed       = evt.now - last_update_reg;
        hold_hit      = held > {16'd0, hold_time};
        step_hit      = elapsed > {16'd0, step_interval};
        flash_hit     = elapsed > {16'd0, flash_interval};
        chase_pattern = ~(LED_W'(1) << chase_reg);
    end

    // Button edges, hold-to-idle, then the LED update of the resulting mode.
    always_comb
    begin
        mode_edge         = mode_reg;
        led_base          = led_reg;
        hold_pending_next = hold_pending_reg;
        press_start_next  = press_start_reg;
        last_update_next  = last_update_reg;
        chase_next        = chase_reg;

        if (evt.edge_up)
        begin
            mode_edge = MODE_UP;
        end
        if (evt.edge_down)
        begin
            mode_edge = MODE_DOWN;
        end
        if (evt.edge_flash)
        begin
            mode_edge         = MODE_FLASH;
            led_base          = LED_ALL_OFF;
            hold_pending_next = 1'b1;
            press_start_next  = evt.now;
        end
        else if (hold_pending_reg)
        begin
            // Release is seen on the raw level, not the debounced one.
            if (evt.raw_flash)
            begin
                hold_pending_next = 1'b0;
            end
            else if (hold_hit)
            begin
                hold_pending_next = 1'b0;
                mode_edge         = MODE_IDLE;
            end
        end

        mode_next = mode_edge;
        led_next  = led_base;
        case (mode_edge)
            MODE_UP:
            begin
                if (step_hit)
                begin
                    last_update_next = evt.now;
                    led_next         = chase_pattern;
                    chase_next       = chase_reg + 2'd1;
                end
            end
            MODE_DOWN:
            begin
                if (step_hit)
                begin
                    last_update_next = evt.now;
                    led_next         = chase_pattern;
                    chase_next       = chase_reg - 2'd1;
                end
            end
            MODE_FLASH:
            begin
                if (flash_hit)
                begin
                    last_update_next = evt.now;
                    led_next         = led_base ^ LED_ALL_OFF;
                end
            end
            default:
            begin
                led_next = LED_ALL_OFF;
            end
        endcase

        // Without a scan the state and the shown result stay as they are.
        if (!evt.scan)
        begin
            mode_next = mode_reg;
            led_next  = led_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_IDLE;
            led_reg          <= LED_ALL_ON;
            chase_reg        <= 2'd0;
            hold_pending_reg <= 1'b0;
            last_update_reg  <= '0;
            press_start_reg  <= '0;
        end
        else if (evt.scan)
        begin
            mode_reg         <= mode_next;
            led_reg          <= led_next;
            chase_reg        <= chase_next;
            hold_pending_reg <= hold_pending_next;
            last_update_reg  <= last_update_next;
            press_start_reg  <= press_start_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/button_led_mode_controller.sv =====
// Path: a tick beat passes the input register, then the result register, before its
// result beat leaves.
// Throughput: one tick beat per cycle; each stage holds while the stage after it stalls.
// Reset: rst_n is asynchronous, active low. It clears time, scan schedule, debouncers,
// sets mode to idle with all LEDs lit, and loads the default configuration.
`default_nettype none

module button_led_mode_controller (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write_en,
    input  wire logic [blmc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [blmc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                incr_button_level,
    input  wire logic                                decr_button_level,
    input  wire logic                                flash_button_level,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [3:0]                               led_drive,
    output logic [1:0]                               current_mode_out
);

    import blmc_pkg::*;

    logic [7:0]        scan_period_reg;
    logic [15:0]       step_interval_reg;
    logic [15:0]       flash_interval_reg;
    logic [15:0]       hold_time_reg;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic              s1_incr_reg;
    logic              s1_decr_reg;
    logic              s1_flash_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [LED_W-1:0]  out_led_reg;
    mode_t             out_mode_reg;

    logic [TIME_W-1:0] time_count_reg;
    logic [TIME_W-1:0] next_scan_reg;

    logic              in_accept;
    logic              advance;
    logic              fire;
    logic              scan;
    logic              rise_up;
    logic              rise_down;
    logic              rise_flash;
    scan_evt_t         evt;
    logic [LED_W-1:0]  led_next;
    mode_t             mode_next;

    // Configuration regs, written only while the block is idle: user rule, not checked.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_period_reg    <= SCAN_PERIOD_RST;
            step_interval_reg  <= STEP_INTERVAL_RST;
            flash_interval_reg <= FLASH_INTERVAL_RST;
            hold_time_reg      <= HOLD_TIME_RST;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_SCAN_PERIOD:    scan_period_reg    <= cfg_data[7:0];
                CFG_STEP_INTERVAL:  step_interval_reg  <= cfg_data;
                CFG_FLASH_INTERVAL: flash_interval_reg <= cfg_data;
                CFG_HOLD_TIME:      hold_time_reg      <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Handshake: stage one moves on when the result register is free or drains.
    always_comb
    begin
        advance        = !out_valid_reg || out_ready;
        fire           = s1_valid_reg && advance;
        in_ready       = !s1_valid_reg || advance;
        in_accept      = in_valid && in_ready;
        s1_valid_next  = in_accept ? 1'b1 : (fire ? 1'b0 : s1_valid_reg);
        out_valid_next = fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register for the button levels of one tick beat.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_incr_reg  <= incr_button_level;
            s1_decr_reg  <= decr_button_level;
            s1_flash_reg <= flash_button_level;
        end
    end

    // Tick time and scan schedule.
    assign scan = fire && (time_count_reg >= next_scan_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_count_reg <= '0;
            next_scan_reg  <= '0;
        end
        else if (fire)
        begin
            time_count_reg <= time_count_reg + TIME_W'(1);
            if (scan)
            begin
                next_scan_reg <= next_scan_reg + {24'd0, scan_period_reg};
            end
        end
    end

    // One debouncer per button; buttons are active low on the pins.
    blmc_debounce u_deb_up (
        .clk     (clk),
        .rst_n   (rst_n),
        .scan    (scan),
        .pressed (~s1_incr_reg),
        .rise    (rise_up)
    );

    blmc_debounce u_deb_down (
        .clk     (clk),
        .rst_n   (rst_n),
        .scan    (scan),
        .pressed (~s1_decr_reg),
        .rise    (rise_down)
    );

    blmc_debounce u_deb_flash (
        .clk     (clk),
        .rst_n   (rst_n),
        .scan    (scan),
        .pressed (~s1_flash_reg),
        .rise    (rise_flash)
    );

    always_comb
    begin
        evt.scan       = scan;
        evt.edge_up    = rise_up;
        evt.edge_down  = rise_down;
        evt.edge_flash = rise_flash;
        evt.raw_flash  = s1_flash_reg;
        evt.now        = time_count_reg;
    end

    blmc_mode_ctrl u_mode (
        .clk            (clk),
        .rst_n          (rst_n),
        .evt            (evt),
        .step_interval  (step_interval_reg),
        .flash_interval (flash_interval_reg),
        .hold_time      (hold_time_reg),
        .led_next       (led_next),
        .mode_next      (mode_next)
    );

    // Result register.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_led_reg  <= led_next;
            out_mode_reg <= mode_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign led_drive        = out_led_reg;
    assign current_mode_out = out_mode_reg;

endmodule

`default_nettype wire

// ===== tb/sv/blmc_tick_checker.sv =====
`timescale 1ns / 100ps

module blmc_tick_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_en,
    input  logic [blmc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [blmc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic                             incr_button_level,
    input  logic                             decr_button_level,
    input  logic                             flash_button_level,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic [3:0]                       led_drive,
    input  logic [1:0]                       current_mode_out,
    output int                               fail_count,
    output int                               pending_count
);
    import blmc_pkg::*;

    // LED pins and mode that one tick beat should produce.
    typedef struct packed {
        logic [LED_W-1:0] led;
        mode_t            mode;
    } pin_state_t;

    pin_state_t pins_due[$];

    // Our copy of the configuration registers.
    logic [7:0]  scan_period;
    logic [15:0] step_interval;
    logic [15:0] flash_interval;
    logic [15:0] hold_time;

    // Our copy of the controller state.
    logic [TIME_W-1:0] now_ms;
    logic [TIME_W-1:0] next_scan_ms;
    logic [TIME_W-1:0] last_move_ms;
    logic [TIME_W-1:0] press_start_ms;
    logic [2:0]        samples [3];
    logic              settled [3];
    logic              hold_armed;
    mode_t             mode;
    logic [1:0]        chase_pos;
    logic [LED_W-1:0]  led_state;
    int                mismatches;

    function automatic void clear_state();
        int b;
        scan_period    = SCAN_PERIOD_RST;
        step_interval  = STEP_INTERVAL_RST;
        flash_interval = FLASH_INTERVAL_RST;
        hold_time      = HOLD_TIME_RST;
        now_ms         = '0;
        next_scan_ms   = '0;
        last_move_ms   = '0;
        press_start_ms = '0;
        for (b = 0; b < 3; b++)
        begin
            samples[b] = 3'b000;
            settled[b] = 1'b0;
        end
        hold_armed = 1'b0;
        mode       = MODE_IDLE;
        chase_pos  = 2'd0;
        led_state  = LED_ALL_ON;
    endfunction

    // Writes to an index outside the register set are dropped.
    function automatic void write_reg(input logic [CFG_INDEX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_SCAN_PERIOD:    scan_period    = val[7:0];
            CFG_STEP_INTERVAL:  step_interval  = val;
            CFG_FLASH_INTERVAL: flash_interval = val;
            CFG_HOLD_TIME:      hold_time      = val;
            default: ;
        endcase
    endfunction

    // Three-sample debounce with hysteresis; returns a rising edge of "pressed".
    function automatic logic settle_button(input int b, input logic pressed);
        logic [2:0] h;
        logic       prev;
        logic       cur;
        h    = {samples[b][1:0], pressed};
        prev = settled[b];
        cur  = (prev & (h != 3'b000)) | (h == 3'b111);
        samples[b] = h;
        settled[b] = cur;
        return cur && !prev;
    endfunction

    function automatic void scan_buttons(input logic [2:0] raw);
        logic              up_edge;
        logic              down_edge;
        logic              flash_edge;
        logic [TIME_W-1:0] held;
        logic [TIME_W-1:0] elapsed;
        up_edge    = settle_button(0, !raw[0]);
        down_edge  = settle_button(1, !raw[1]);
        flash_edge = settle_button(2, !raw[2]);

        // Edges in the same scan are taken in button order, the last one wins.
        if (up_edge)
            mode = MODE_UP;
        if (down_edge)
            mode = MODE_DOWN;
        if (flash_edge)
        begin
            led_state      = LED_ALL_OFF;
            mode           = MODE_FLASH;
            hold_armed     = 1'b1;
            press_start_ms = now_ms;
        end

        // A long hold of the flash button goes back to idle; a raw release cancels it.
        if (hold_armed)
        begin
            held = now_ms - press_start_ms;
            if (raw[2])
                hold_armed = 1'b0;
            else if (held > {16'd0, hold_time})
            begin
                hold_armed = 1'b0;
                mode       = MODE_IDLE;
            end
        end

        elapsed = now_ms - last_move_ms;
        case (mode)
            MODE_UP:
                if (elapsed > {16'd0, step_interval})
                begin
                    last_move_ms = now_ms;
                    led_state    = ~(4'b0001 << chase_pos);
                    chase_pos    = chase_pos + 2'd1;
                end
            MODE_DOWN:
                if (elapsed > {16'd0, step_interval})
                begin
                    last_move_ms = now_ms;
                    led_state    = ~(4'b0001 << chase_pos);
                    chase_pos    = chase_pos - 2'd1;
                end
            MODE_FLASH:
                if (elapsed > {16'd0, flash_interval})
                begin
                    last_move_ms = now_ms;
                    led_state    = ~led_state;
                end
            default:
                led_state = LED_ALL_OFF;
        endcase
    endfunction

    // One millisecond tick: scan when due, report the pins, then advance time.
    function automatic pin_state_t advance_one_ms(input logic [2:0] raw);
        pin_state_t res;
        if (now_ms >= next_scan_ms)
        begin
            next_scan_ms = next_scan_ms + {24'd0, scan_period};
            scan_buttons(raw);
        end
        res.led  = led_state;
        res.mode = mode;
        now_ms   = now_ms + 32'd1;
        return res;
    endfunction

    // Compare each result beat with the oldest prediction, then predict new tick beats.
    always @(posedge clk or negedge rst_n)
    begin : watch
        pin_state_t want;
        if (!rst_n)
        begin
            clear_state();
            pins_due.delete();
            mismatches = 0;
        end
        else
        begin
            if (cfg_write_en)
                write_reg(cfg_index, cfg_data);

            if (out_valid && out_ready)
            begin
                if (pins_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result beat led=%h mode=%0d",
                                 $time, led_drive, current_mode_out);
                end
                else
                begin
                    want = pins_due.pop_front();
                    if (led_drive !== want.led || current_mode_out !== want.mode)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: result mismatch led exp=%h got=%h, mode exp=%0d got=%0d",
                                     $time, want.led, led_drive, want.mode, current_mode_out);
                    end
                end
            end

            if (in_valid && in_ready)
                pins_due.push_back(advance_one_ms({flash_button_level, decr_button_level,
                                                   incr_button_level}));
        end
        fail_count    <= mismatches;
        pending_count <= pins_due.size();
    end

endmodule

// ===== tb/sv/tb_button_led_mode_controller.sv =====
`timescale 1ns / 100ps

module tb_button_led_mode_controller;
    import blmc_pkg::*;

    localparam int PIPE_DEPTH  = 2;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;

    // Indexes past the register set; writes there must change nothing.
    localparam logic [CFG_INDEX_W-1:0] CFG_NONE_NEXT = 8'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_NONE_LAST = 8'hFF;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_write_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic                   incr_button_level;
    logic                   decr_button_level;
    logic                   flash_button_level;
    logic                   out_valid;
    logic                   out_ready;
    logic [3:0]             led_drive;
    logic [1:0]             current_mode_out;
    int                     fail_count;
    int                     pending_count;

    // Shaping of the traffic.
    logic calm           = 1'b0;
    logic long_hold_req  = 1'b0;
    logic long_hold_done = 1'b0;
    int   cur_scan;
    int   cur_hold;
    int   ticks_left;

    always #2 clk = ~clk;

    button_led_mode_controller i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write_en       (cfg_write_en),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .incr_button_level  (incr_button_level),
        .decr_button_level  (decr_button_level),
        .flash_button_level (flash_button_level),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .led_drive          (led_drive),
        .current_mode_out   (current_mode_out)
    );

    blmc_tick_checker i_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write_en       (cfg_write_en),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .incr_button_level  (incr_button_level),
        .decr_button_level  (decr_button_level),
        .flash_button_level (flash_button_level),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .led_drive          (led_drive),
        .current_mode_out   (current_mode_out),
        .fail_count         (fail_count),
        .pending_count      (pending_count)
    );

    // Gap length: mostly none or short, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm)
            return 0;
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Offer one tick beat and wait until it is taken.
    task automatic send_tick(input logic [2:0] lv);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid           <= 1'b1;
        incr_button_level  <= lv[0];
        decr_button_level  <= lv[1];
        flash_button_level <= lv[2];
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Hold one set of levels for a number of ticks, within the phase budget.
    task automatic feed(input logic [2:0] lv, input int len);
        repeat (len)
        begin
            if (ticks_left > 0)
            begin
                send_tick(lv);
                ticks_left--;
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_regs(input logic [15:0] sp, input logic [15:0] step,
                            input logic [15:0] flash, input logic [15:0] hold);
        write_reg(CFG_SCAN_PERIOD, sp);
        write_reg(CFG_STEP_INTERVAL, step);
        write_reg(CFG_FLASH_INTERVAL, flash);
        write_reg(CFG_HOLD_TIME, hold);
        cur_scan = int'(sp[7:0]);
        cur_hold = int'(hold);
    endtask

    // Stop sending and wait until every result beat has come back.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 2) @(posedge clk);
    endtask

    // Mostly press and release sequences long enough to debounce, some raw noise.
    task automatic random_phase(input int n);
        int         sp;
        int         len;
        logic [2:0] mask;
        sp = (cur_scan == 0) ? 1 : cur_scan;
        ticks_left = n;
        while (ticks_left > 0)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                if ($urandom_range(0, 2) != 0)
                    mask = 3'b001 << $urandom_range(0, 2);
                else
                    mask = 3'($urandom_range(1, 7));
                len = sp * $urandom_range(2, 6);
                if (mask[2] && cur_hold <= 100 && $urandom_range(0, 1) == 1)
                    len = len + cur_hold + 2 * sp;
                feed(~mask, len);
                feed(3'b111, sp * $urandom_range(1, 5));
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    feed(3'($urandom), 1);
            end
        end
    endtask

    // Result side: random stalls, plus one long hold-off while the sender keeps going.
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req && !long_hold_done)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_done = 1'b1;
            end
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                stall_left = idle_len();
            end
        end
    end

    // Run limit.
    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int ph;
        rst_n              <= 1'b0;
        in_valid           <= 1'b0;
        incr_button_level  <= 1'b1;
        decr_button_level  <= 1'b1;
        flash_button_level <= 1'b1;
        cfg_write_en       <= 1'b0;
        cfg_index          <= '0;
        cfg_data           <= '0;
        cur_scan = int'(SCAN_PERIOD_RST);
        cur_hold = int'(HOLD_TIME_RST);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A few ticks on the reset configuration, including the scan at time zero.
        ticks_left = 4;
        feed(3'b111, 1);
        feed(3'b000, 1);
        feed(3'b010, 1);
        feed(3'b101, 1);
        drain();

        // Scan every tick; stray writes past the register set must be ignored.
        set_regs(16'h0001, 16'h0000, 16'h0001, 16'h0004);
        write_reg(CFG_NONE_NEXT, 16'hFFFF);
        write_reg(CFG_NONE_LAST, 16'h0000);

        // All buttons together: flash wins, then the hold runs out to idle.
        // Then two chase buttons at once (down wins), and a short flash press
        // whose raw release cancels the hold.
        ticks_left = 21;
        feed(3'b000, 8);
        feed(3'b111, 3);
        feed(3'b100, 3);
        feed(3'b111, 3);
        feed(3'b011, 3);
        feed(3'b111, 1);
        drain();

        for (ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: set_regs(16'h0001, 16'h0000, 16'h0000, 16'h0000);
                // Upper bits only: scan period becomes zero, so every tick scans.
                1: set_regs(16'h0100, 16'h0001, 16'h0002, 16'h0005);
                2: set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                default: set_regs({8'($urandom), 8'($urandom_range(1, 4))},
                                  16'($urandom_range(0, 20)),
                                  16'($urandom_range(0, 20)),
                                  16'($urandom_range(0, 40)));
            endcase
            calm          = (ph == 3) || (ph == 5);
            long_hold_req = (ph == 3);
            random_phase((ph == 2) ? 30 : 70);
            drain();
        end

        if (fail_count == 0 && pending_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/blmc_pkg.sv
src/blmc_debounce.sv
src/blmc_mode_ctrl.sv
src/button_led_mode_controller.sv
tb/sv/blmc_tick_checker.sv
tb/sv/tb_button_led_mode_controller.sv
